FILE: src/rtn_pkg.sv
// Package for the ray/triangle nearest-hit block: widths, register indexes,
// and shared types. No dependencies.
package rtn_pkg;
  localparam int CoordW = 32;
  localparam int DistW  = 31;
  localparam int CfgIdxW = 3;
  localparam int WideW  = 128;
  localparam int NumRegs = 7;
  // Divider width: the shifted distance numerator stays below 2^115.
  localparam int DivW   = 116;

  localparam logic [CfgIdxW-1:0] REG_OX  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OY  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DX  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DY  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DZ  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LIM = 3'd6;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_a_x, vertex_a_y, vertex_a_z;
    logic signed [CoordW-1:0] vertex_b_x, vertex_b_y, vertex_b_z;
    logic signed [CoordW-1:0] vertex_c_x, vertex_c_y, vertex_c_z;
    logic                     last_triangle;
  } tri_in_t;

  typedef struct packed {
    logic             tri_hit;
    logic [DistW-1:0] tri_distance;
    logic             nearest_valid;
    logic [DistW-1:0] nearest_distance;
    logic             mesh_done;
  } tri_out_t;
endpackage

FILE: src/rtn_if.sv
// Valid/ready channel interfaces for the ray/triangle block.
// Depends on rtn_pkg.
interface rtn_in_if;
  logic           valid;
  logic           ready;
  rtn_pkg::tri_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtn_out_if;
  logic            valid;
  logic            ready;
  rtn_pkg::tri_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/ray_triangle_nearest_hit.sv
// Ray/triangle nearest-hit block: double-sided Moller-Trumbore test on a
// shared 33x35 multiply-accumulate unit stepped by a sequencer, with a serial divider.
// A miss ends after the multiply steps; a hit also takes the divider's 116 steps.
// Input is not ready while an item is in work, so items are taken one at a time.
// The result sits in an output register; a new item is taken once the last one moved there.
// Reset (synchronous, active low) loads the register reset values and clears the nearest hit.
module ray_triangle_nearest_hit (
  input  logic                        clk,
  input  logic                        rst_n,
  rtn_in_if.sink                      in_ch,
  rtn_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [rtn_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rtn_pkg::CoordW-1:0]  cfg_data
);
  import rtn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_DIV = 3'd2,
                         S_WAIT = 3'd3, S_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic signed [CoordW-1:0] ox_r, oy_r, oz_r, dx_r, dy_r, dz_r;
  logic [CoordW-1:0] lim_r;

  // Edge vectors and origin offset, 33-bit signed.
  logic signed [32:0] e1_r [3];
  logic signed [32:0] e2_r [3];
  logic signed [32:0] tv_r [3];
  logic signed [32:0] d_r  [3];
  // Cross products, 67-bit signed.
  logic signed [66:0] pv_r [3];
  logic signed [66:0] qv_r [3];
  logic signed [WideW-1:0] acc_r, det_r, un_r, vn_r;
  logic last_r;
  logic [5:0] step_r;
  logic half_r;

  logic best_valid_r;
  logic [DistW-1:0] best_distance_r;
  tri_out_t res_r;
  logic out_valid_r;

  // Step schedule: 12 cross-product terms, then 12 dot-product terms. Each dot term
  // is done in two halves, the low and then the high part of the wide operand.
  logic signed [32:0]  mul_a;
  logic signed [66:0]  mul_b;
  logic signed [34:0]  mul_bp;
  logic signed [67:0]  pprod;
  logic                mul_neg;
  logic signed [WideW-1:0] prod;

  always_comb begin
    mul_a = '0; mul_b = '0; mul_neg = 1'b0;
    case (step_r)
      6'd0:  begin mul_a = d_r[1];  mul_b = 67'(e2_r[2]); end
      6'd1:  begin mul_a = d_r[2];  mul_b = 67'(e2_r[1]); mul_neg = 1'b1; end
      6'd2:  begin mul_a = d_r[2];  mul_b = 67'(e2_r[0]); end
      6'd3:  begin mul_a = d_r[0];  mul_b = 67'(e2_r[2]); mul_neg = 1'b1; end
      6'd4:  begin mul_a = d_r[0];  mul_b = 67'(e2_r[1]); end
      6'd5:  begin mul_a = d_r[1];  mul_b = 67'(e2_r[0]); mul_neg = 1'b1; end
      6'd6:  begin mul_a = tv_r[1]; mul_b = 67'(e1_r[2]); end
      6'd7:  begin mul_a = tv_r[2]; mul_b = 67'(e1_r[1]); mul_neg = 1'b1; end
      6'd8:  begin mul_a = tv_r[2]; mul_b = 67'(e1_r[0]); end
      6'd9:  begin mul_a = tv_r[0]; mul_b = 67'(e1_r[2]); mul_neg = 1'b1; end
      6'd10: begin mul_a = tv_r[0]; mul_b = 67'(e1_r[1]); end
      6'd11: begin mul_a = tv_r[1]; mul_b = 67'(e1_r[0]); mul_neg = 1'b1; end
      6'd12: begin mul_a = e1_r[0]; mul_b = pv_r[0]; end
      6'd13: begin mul_a = e1_r[1]; mul_b = pv_r[1]; end
      6'd14: begin mul_a = e1_r[2]; mul_b = pv_r[2]; end
      6'd15: begin mul_a = tv_r[0]; mul_b = pv_r[0]; end
      6'd16: begin mul_a = tv_r[1]; mul_b = pv_r[1]; end
      6'd17: begin mul_a = tv_r[2]; mul_b = pv_r[2]; end
      6'd18: begin mul_a = d_r[0];  mul_b = qv_r[0]; end
      6'd19: begin mul_a = d_r[1];  mul_b = qv_r[1]; end
      6'd20: begin mul_a = d_r[2];  mul_b = qv_r[2]; end
      6'd21: begin mul_a = e2_r[0]; mul_b = qv_r[0]; end
      6'd22: begin mul_a = e2_r[1]; mul_b = qv_r[1]; end
      6'd23: begin mul_a = e2_r[2]; mul_b = qv_r[2]; end
      default: ;
    endcase
    // Cross terms fit the narrow operand directly; dot terms are split in two parts.
    if (step_r < 6'd12) mul_bp = mul_b[34:0];
    else if (half_r) mul_bp = {{2{mul_b[66]}}, mul_b[66:34]};
    else mul_bp = {1'b0, mul_b[33:0]};
    pprod = mul_a * mul_bp;
    prod = half_r ? (WideW'(pprod) <<< 34) : WideW'(pprod);
  end

  logic signed [WideW-1:0] acc_sum;
  assign acc_sum = mul_neg ? acc_r - prod : acc_r + prod;
  // A group ends every second step in the cross phase, every third in the dot phase.
  logic grp_end;
  assign grp_end = (step_r < 6'd12) ? step_r[0] :
                   half_r && (step_r == 6'd14 || step_r == 6'd17 || step_r == 6'd20 ||
                              step_r == 6'd23);
  logic dot_last;
  assign dot_last = (step_r == 6'd23) && half_r;

  // Decision from the sign-normalized numerators, tn taken from acc_sum.
  logic signed [WideW-1:0] dn, unn, vnn, tnn;
  logic det_neg, pass;
  always_comb begin
    det_neg = det_r[WideW-1];
    dn  = det_neg ? -det_r  : det_r;
    unn = det_neg ? -un_r   : un_r;
    vnn = det_neg ? -vn_r   : vn_r;
    tnn = det_neg ? -acc_sum : acc_sum;
    pass = (dn != '0) && (dn >= $signed({96'd0, lim_r})) && !unn[WideW-1] &&
           (unn <= dn) && !vnn[WideW-1] && ((unn + vnn) <= dn) && !tnn[WideW-1];
  end

  logic [DivW-1:0] div_num_r;
  logic [DivW-1:0] div_den_r;
  logic div_start;
  logic div_busy;
  logic [DistW-1:0] quo;

  rtn_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num_r), .den(div_den_r),
    .busy(div_busy), .quo(quo)
  );

  assign div_start = (state_r == S_DIV);

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = res_r;

  logic fin;
  logic [DistW-1:0] fin_dist;
  logic fin_hit;

  always_comb begin
    state_nxt = state_r;
    fin = 1'b0; fin_hit = 1'b0; fin_dist = '0;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_MUL;
      S_MUL: begin
        if (dot_last) begin
          if (pass) state_nxt = S_DIV;
          else begin fin = 1'b1; state_nxt = S_OUT; end
        end
      end
      S_DIV: state_nxt = S_WAIT;
      S_WAIT: if (!div_busy) begin
        fin = 1'b1; fin_hit = 1'b1; fin_dist = quo; state_nxt = S_OUT;
      end
      S_OUT: if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Results enter the output register only when it is empty or its item is being read.
  logic upd_best;
  logic [DistW-1:0] nb_dist;
  logic nb_valid;
  always_comb begin
    upd_best = fin_hit && (!best_valid_r || fin_dist < best_distance_r);
    nb_valid = best_valid_r | upd_best;
    nb_dist  = upd_best ? fin_dist : best_distance_r;
  end

  logic pend_r;
  tri_out_t pend_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; step_r <= '0; half_r <= 1'b0;
      ox_r <= '0; oy_r <= '0; oz_r <= '0; dx_r <= '0; dy_r <= '0;
      dz_r <= 32'sd65536; lim_r <= 32'd1;
      best_valid_r <= 1'b0; best_distance_r <= '0;
      out_valid_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OX:  ox_r <= cfg_data;
          REG_OY:  oy_r <= cfg_data;
          REG_OZ:  oz_r <= cfg_data;
          REG_DX:  dx_r <= cfg_data;
          REG_DY:  dy_r <= cfg_data;
          REG_DZ:  dz_r <= cfg_data;
          REG_LIM: lim_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_IDLE) begin
        step_r <= '0; half_r <= 1'b0;
      end else if (state_r == S_MUL) begin
        if (step_r < 6'd12 || half_r) step_r <= step_r + 6'd1;
        if (step_r >= 6'd12) half_r <= !half_r;
      end
      if (fin) begin
        pend_r <= 1'b1;
        pend_res_r <= '{tri_hit: fin_hit, tri_distance: fin_dist, nearest_valid: nb_valid,
                        nearest_distance: nb_valid ? nb_dist : '0,
                        mesh_done: last_r};
        best_valid_r <= last_r ? 1'b0 : nb_valid;
        best_distance_r <= last_r ? '0 : nb_dist;
      end
      if (pend_r && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1; pend_r <= 1'b0;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pend_r && (!out_valid_r || out_ch.ready)) res_r <= pend_res_r;
    if (state_r == S_IDLE && in_ch.valid) begin
      e1_r[0] <= 33'(in_ch.data.vertex_b_x) - 33'(in_ch.data.vertex_a_x);
      e1_r[1] <= 33'(in_ch.data.vertex_b_y) - 33'(in_ch.data.vertex_a_y);
      e1_r[2] <= 33'(in_ch.data.vertex_b_z) - 33'(in_ch.data.vertex_a_z);
      e2_r[0] <= 33'(in_ch.data.vertex_c_x) - 33'(in_ch.data.vertex_a_x);
      e2_r[1] <= 33'(in_ch.data.vertex_c_y) - 33'(in_ch.data.vertex_a_y);
      e2_r[2] <= 33'(in_ch.data.vertex_c_z) - 33'(in_ch.data.vertex_a_z);
      tv_r[0] <= 33'(ox_r) - 33'(in_ch.data.vertex_a_x);
      tv_r[1] <= 33'(oy_r) - 33'(in_ch.data.vertex_a_y);
      tv_r[2] <= 33'(oz_r) - 33'(in_ch.data.vertex_a_z);
      d_r[0] <= 33'(dx_r); d_r[1] <= 33'(dy_r); d_r[2] <= 33'(dz_r);
      last_r <= in_ch.data.last_triangle;
      acc_r <= '0;
    end else if (state_r == S_MUL) begin
      acc_r <= grp_end ? '0 : acc_sum;
      if (grp_end) begin
        case (step_r)
          6'd1:  pv_r[0] <= acc_sum[66:0];
          6'd3:  pv_r[1] <= acc_sum[66:0];
          6'd5:  pv_r[2] <= acc_sum[66:0];
          6'd7:  qv_r[0] <= acc_sum[66:0];
          6'd9:  qv_r[1] <= acc_sum[66:0];
          6'd11: qv_r[2] <= acc_sum[66:0];
          6'd14: det_r <= acc_sum;
          6'd17: un_r <= acc_sum;
          6'd20: vn_r <= acc_sum;
          default: ;
        endcase
      end
      if (dot_last) begin
        div_num_r <= {tnn[DivW-17:0], 16'd0};
        div_den_r <= dn[DivW-1:0];
      end
    end
  end

  // The output holds its item while the sink stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(res_r))
    else $error("result changed under stall");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> !in_ch.ready)
    else $error("input ready during work");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.tri_hit |-> res_r.tri_distance == '0)
    else $error("miss with nonzero distance");
  a_nearest_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.tri_hit |-> res_r.nearest_valid &&
      res_r.nearest_distance <= res_r.tri_distance)
    else $error("nearest above own hit");
endmodule

FILE: src/rtn_div.sv
// Restoring serial divider, one quotient bit per cycle, saturating to the
// distance width. Depends on rtn_pkg.
module rtn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rtn_pkg::DivW-1:0]  num,
  input  logic [rtn_pkg::DivW-1:0]  den,
  output logic                      busy,
  output logic [rtn_pkg::DistW-1:0] quo
);
  import rtn_pkg::*;
  // The numerator is below 2^115 and the divisor below 2^98, so both fit DivW bits.
  logic [DivW-1:0] n_r, n_nxt;
  logic [DivW:0]   rem_r, rem_nxt;
  logic [DivW-1:0] q_r, q_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [DivW:0] sh;

  always_comb begin
    n_nxt = n_r; rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    sh = {rem_r[DivW-1:0], n_r[DivW-1]};
    if (start) begin
      n_nxt = num; rem_nxt = '0; q_nxt = '0; cnt_nxt = 7'(DivW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[DivW-2:0], 1'b0};
      if (sh >= {1'b0, den}) begin
        rem_nxt = sh - {1'b0, den};
        q_nxt = {q_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
  end

  assign busy = busy_r;
  assign quo = (|q_r[DivW-1:DistW]) ? {DistW{1'b1}} : q_r[DistW-1:0];
endmodule

FILE: tb/sv/ray_triangle_nearest_hit_test.sv
// Self-checking testbench for ray_triangle_nearest_hit: drives triangle items under
// several ray settings and checks every result against an exact integer predictor.
// Depends on rtn_pkg, rtn_if.sv and ray_triangle_nearest_hit.sv.
`timescale 1ns / 100ps

module ray_triangle_nearest_hit_test;
  import rtn_pkg::*;

  typedef logic signed [WideW-1:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoordW-1:0] cfg_data = '0;

  rtn_in_if in_ch ();
  rtn_out_if out_ch ();

  ray_triangle_nearest_hit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Ray settings as the block should hold them.
  logic [CoordW-1:0] ray_org [3];
  logic [CoordW-1:0] ray_dir [3];
  logic [CoordW-1:0] par_limit;
  logic [DistW-1:0] mesh_best_dist;
  logic mesh_best_valid;

  tri_in_t pending_tris[$];
  tri_out_t expected_hits[$];
  int errors = 0;
  int tris_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int meshes_done = 0;
  int cycle_count = 0;
  logic offer_taken = 1'b0;
  logic hold_rx = 1'b0;
  logic hold_used = 1'b0;

  function automatic wide_t widen(logic [CoordW-1:0] v);
    return {{(WideW-CoordW){v[CoordW-1]}}, v};
  endfunction

  function automatic tri_out_t intersect_tri(tri_in_t t);
    wide_t a[3], b[3], c[3], d[3], e1[3], e2[3], tv[3], pv[3], qv[3];
    wide_t det, un, vn, tn, lim;
    logic [WideW-1:0] shifted, quot;
    logic [DistW-1:0] hit_dist;
    logic hit;
    tri_out_t r;
    a[0] = widen(t.vertex_a_x); a[1] = widen(t.vertex_a_y); a[2] = widen(t.vertex_a_z);
    b[0] = widen(t.vertex_b_x); b[1] = widen(t.vertex_b_y); b[2] = widen(t.vertex_b_z);
    c[0] = widen(t.vertex_c_x); c[1] = widen(t.vertex_c_y); c[2] = widen(t.vertex_c_z);
    for (int i = 0; i < 3; i++) begin
      d[i] = widen(ray_dir[i]);
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      tv[i] = widen(ray_org[i]) - a[i];
    end
    pv[0] = d[1]*e2[2] - d[2]*e2[1];
    pv[1] = d[2]*e2[0] - d[0]*e2[2];
    pv[2] = d[0]*e2[1] - d[1]*e2[0];
    qv[0] = tv[1]*e1[2] - tv[2]*e1[1];
    qv[1] = tv[2]*e1[0] - tv[0]*e1[2];
    qv[2] = tv[0]*e1[1] - tv[1]*e1[0];
    det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
    un = tv[0]*pv[0] + tv[1]*pv[1] + tv[2]*pv[2];
    vn = d[0]*qv[0] + d[1]*qv[1] + d[2]*qv[2];
    tn = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
    // Double-sided: fold a negative determinant onto the positive side.
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    lim = {{(WideW-CoordW){1'b0}}, par_limit};
    hit = (det != 0) && !(det < lim) && !(un < 0) && !(det < un) && !(vn < 0) &&
          !(det < un + vn) && !(tn < 0);
    hit_dist = '0;
    if (hit) begin
      shifted = tn << 16;
      quot = shifted / det;
      hit_dist = (quot > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : quot[DistW-1:0];
    end
    if (hit && (!mesh_best_valid || hit_dist < mesh_best_dist)) begin
      mesh_best_dist = hit_dist;
      mesh_best_valid = 1'b1;
    end
    r.tri_hit = hit;
    r.tri_distance = hit_dist;
    r.nearest_valid = mesh_best_valid;
    r.nearest_distance = mesh_best_valid ? mesh_best_dist : '0;
    r.mesh_done = t.last_triangle;
    if (t.last_triangle) begin
      mesh_best_dist = '0;
      mesh_best_valid = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d, expected %0d", results_seen, field, got,
             want);
    errors++;
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Acceptance of an input item: predict and retire it from the pending queue.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_hits.push_back(intersect_tri(in_ch.data));
      void'(pending_tris.pop_front());
      tris_sent++;
      offer_taken = 1'b1;
    end
  end

  // Driver: long calm stretch with no idling, otherwise idles about 31 percent.
  always @(negedge clk) begin
    if (!in_ch.valid || offer_taken) begin
      offer_taken = 1'b0;
      if (rst_n && pending_tris.size() > 0 &&
          ((cycle_count > 20000 && cycle_count < 40000) || $urandom_range(99) >= 31)) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_tris[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // One long receiver hold-off while the sender keeps offering items.
  always @(negedge clk) begin
    if (!hold_used && tris_sent >= 150) begin
      hold_used <= 1'b1;
      hold_rx <= 1'b1;
      repeat (800) @(negedge clk);
      hold_rx <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !hold_rx &&
                    ((cycle_count > 20000 && cycle_count < 40000) || $urandom_range(99) >= 31);
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk) begin
    tri_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_hits.size() == 0) begin
        $display("unexpected result %0d with nothing predicted", results_seen);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (out_ch.data.tri_hit !== want.tri_hit)
          report_mismatch("tri_hit", out_ch.data.tri_hit, want.tri_hit);
        if (out_ch.data.tri_distance !== want.tri_distance)
          report_mismatch("tri_distance", out_ch.data.tri_distance, want.tri_distance);
        if (out_ch.data.nearest_valid !== want.nearest_valid)
          report_mismatch("nearest_valid", out_ch.data.nearest_valid, want.nearest_valid);
        if (out_ch.data.nearest_distance !== want.nearest_distance)
          report_mismatch("nearest_distance", out_ch.data.nearest_distance,
                          want.nearest_distance);
        if (out_ch.data.mesh_done !== want.mesh_done)
          report_mismatch("mesh_done", out_ch.data.mesh_done, want.mesh_done);
        if (want.tri_hit) hits_seen++;
        if (want.mesh_done) meshes_done++;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OX: ray_org[0] = val;
      REG_OY: ray_org[1] = val;
      REG_OZ: ray_org[2] = val;
      REG_DX: ray_dir[0] = val;
      REG_DY: ray_dir[1] = val;
      REG_DZ: ray_dir[2] = val;
      REG_LIM: par_limit = val;
      default: ;
    endcase
  endtask

  task automatic set_ray(logic [CoordW-1:0] ox, oy, oz, dx, dy, dz, lim);
    write_reg(REG_OX, ox); write_reg(REG_OY, oy); write_reg(REG_OZ, oz);
    write_reg(REG_DX, dx); write_reg(REG_DY, dy); write_reg(REG_DZ, dz);
    write_reg(REG_LIM, lim);
  endtask

  task automatic wait_idle();
    while (pending_tris.size() > 0 || expected_hits.size() > 0) @(posedge clk);
    // Leave a quiet gap before the ray settings change.
    repeat (150) @(posedge clk);
  endtask

  function automatic tri_in_t make_tri(logic [CoordW-1:0] ax, ay, az, bx, by, bz,
                                       logic [CoordW-1:0] cx, cy, cz, logic last);
    tri_in_t t;
    t.vertex_a_x = ax; t.vertex_a_y = ay; t.vertex_a_z = az;
    t.vertex_b_x = bx; t.vertex_b_y = by; t.vertex_b_z = bz;
    t.vertex_c_x = cx; t.vertex_c_y = cy; t.vertex_c_z = cz;
    t.last_triangle = last;
    return t;
  endfunction

  // A triangle scattered around a point some way along the ray, so that many are hit.
  function automatic tri_in_t near_tri();
    longint ctr[3];
    longint steps, spread;
    logic [CoordW-1:0] v[9];
    steps = longint'($urandom_range(0, 20)) <<< 16 | longint'($urandom_range(0, 65535));
    if ($urandom_range(9) == 0) steps = -steps;
    case ($urandom_range(2))
      0: spread = 1 << 8;
      1: spread = 1 << 16;
      default: spread = 1 << 20;
    endcase
    for (int i = 0; i < 3; i++)
      ctr[i] = longint'($signed(ray_org[i])) +
               ((longint'($signed(ray_dir[i])) * steps) >>> 16);
    for (int k = 0; k < 9; k++)
      v[k] = CoordW'(ctr[k % 3] + longint'($urandom_range(0, 2 * spread)) - spread);
    return make_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
                    $urandom_range(5) == 0);
  endfunction

  function automatic tri_in_t noise_tri();
    return make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom_range(1));
  endfunction

  task automatic random_tris(int count);
    for (int i = 0; i < count; i++)
      pending_tris.push_back($urandom_range(99) < 75 ? near_tri() : noise_tri());
  endtask

  initial begin
    tri_in_t t;
    ray_org = '{default: '0};
    ray_dir = '{32'd0, 32'd0, 32'd65536};
    par_limit = 32'd1;
    mesh_best_dist = '0;
    mesh_best_valid = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset ray: origin at zero looking along +z.
    pending_tris.push_back(make_tri(-32'sd65536, -32'sd65536, 32'sd327680,
                                    32'sd196608, -32'sd65536, 32'sd327680,
                                    -32'sd65536, 32'sd196608, 32'sd327680, 1'b0));
    // Same triangle again: an equal distance must not replace the nearest.
    pending_tris.push_back(pending_tris[0]);
    // Closer, wound the other way.
    pending_tris.push_back(make_tri(-32'sd65536, -32'sd65536, 32'sd131072,
                                    -32'sd65536, 32'sd196608, 32'sd131072,
                                    32'sd196608, -32'sd65536, 32'sd131072, 1'b1));
    // Behind the origin: negative distance.
    pending_tris.push_back(make_tri(-32'sd65536, -32'sd65536, -32'sd131072,
                                    32'sd196608, -32'sd65536, -32'sd131072,
                                    -32'sd65536, 32'sd196608, -32'sd131072, 1'b0));
    // Edge-on to the ray, zero determinant.
    pending_tris.push_back(make_tri(0, 0, 0, 32'sd65536, 0, 0, 0, 0, 32'sd65536, 1'b0));
    // Degenerate triangle with all vertices equal.
    pending_tris.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 1'b1));
    // Ray through a vertex and through an edge (u or v on the boundary).
    pending_tris.push_back(make_tri(0, 0, 32'sd65536, 32'sd65536, 0, 32'sd65536,
                                    0, 32'sd65536, 32'sd65536, 1'b0));
    pending_tris.push_back(make_tri(-32'sd65536, 0, 32'sd65536, 32'sd65536, 0, 32'sd65536,
                                    0, 32'sd65536, 32'sd65536, 1'b1));
    // Ray outside the triangle in u, in v and beyond u + v.
    pending_tris.push_back(make_tri(32'sd65536, 32'sd65536, 32'sd65536, 32'sd131072,
                                    32'sd65536, 32'sd65536, 32'sd65536, 32'sd131072,
                                    32'sd65536, 1'b0));
    pending_tris.push_back(make_tri(-32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
                                    32'sd65536, 32'sd65536, 0, 32'sd131072, 32'sd65536,
                                    1'b0));
    pending_tris.push_back(make_tri(-32'sd131072, -32'sd131072, 32'sd65536, -32'sd65536,
                                    -32'sd131072, 32'sd65536, -32'sd131072, -32'sd65536,
                                    32'sd65536, 1'b1));
    // Field extremes.
    pending_tris.push_back(make_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    pending_tris.push_back(make_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    wait_idle();

    // Tiny direction with a distant plane: the distance saturates.
    set_ray(0, 0, 0, 0, 0, 32'd1, 32'd0);
    // Out-of-range register index is ignored.
    write_reg(CfgIdxW'(NumRegs), 32'hDEAD_BEEF);
    pending_tris.push_back(make_tri(-32'sd65536, -32'sd65536, 32'h4000_0000,
                                    32'sd196608, -32'sd65536, 32'h4000_0000,
                                    -32'sd65536, 32'sd196608, 32'h4000_0000, 1'b1));
    random_tris(150);
    wait_idle();

    set_ray($urandom_range(0, 1 << 22) - (1 << 21), $urandom_range(0, 1 << 22) - (1 << 21),
            $urandom_range(0, 1 << 22) - (1 << 21), $urandom_range(0, 1 << 18) - (1 << 17),
            $urandom_range(0, 1 << 18) - (1 << 17), $urandom_range(0, 1 << 18) - (1 << 17),
            $urandom_range(0, 64));
    random_tris(350);
    wait_idle();

    set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'd0);
    random_tris(150);
    wait_idle();

    set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
    random_tris(100);
    wait_idle();

    set_ray(32'sd65536, -32'sd131072, 32'sd0, 32'sd40000, -32'sd30000, 32'sd65536,
            32'd1);
    random_tris(250);
    // Close any open mesh so the nearest hit is reported final once more.
    t = near_tri();
    t.last_triangle = 1'b1;
    pending_tris.push_back(t);
    wait_idle();

    $display("covered %0d triangles, %0d results with %0d hits, %0d meshes closed",
             tris_sent, results_seen, hits_seen, meshes_done);
    $display("ray settings swept: reset, saturating, random, extreme, strict limit, skewed");
    if (errors == 0) begin
      $display("PASS ray_triangle_nearest_hit");
    end else begin
      $display("FAIL ray_triangle_nearest_hit");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", expected_hits.size());
    $display("FAIL ray_triangle_nearest_hit");
    $finish;
  end
endmodule
